### hdl/ax25p_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and limits for the ax25 ui frame parser
// no dependencies; used by the core, the top level and the checker
package ax25p_pkg;

  // default limits, overridable on the top level
  localparam int PATH_MAX_DEF = 8;
  localparam int INFO_MAX_DEF = 256;

  // parse phases
  localparam logic [2:0] PH_DEST  = 3'd0;
  localparam logic [2:0] PH_SRC   = 3'd1;
  localparam logic [2:0] PH_RPT   = 3'd2;
  localparam logic [2:0] PH_CTRL  = 3'd3;
  localparam logic [2:0] PH_PID   = 3'd4;
  localparam logic [2:0] PH_INFO  = 3'd5;
  localparam logic [2:0] PH_DRAIN = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_ADDR   = 2'd0;
  localparam logic [1:0] KIND_INFO   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // end-of-frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PARSE    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_NOT_UI   = 2'd3;

  localparam logic [3:0] SLOT_DEST = 4'd0;
  localparam logic [3:0] SLOT_SRC  = 4'd1;
  localparam logic [3:0] SLOT_RPT0 = 4'd2;

  localparam logic [2:0] GROUP_LAST = 3'd6;  // seventh byte of an address
  localparam int         GROUP_BUF  = 6;     // bytes kept before the seventh
  localparam int         LEN_MIN    = 16;
  localparam logic [7:0] CTRL_UI    = 8'h03;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam int         TAIL_INFO  = 4;     // info bytes a short tail can hold

  // every result one input byte causes, in delivery order:
  // address, then info bytes, then status
  typedef struct packed {
    logic                      addr_v;
    logic [3:0]                slot;
    logic [41:0]               chars;
    logic [2:0]                clen;
    logic [3:0]                ssid;
    logic                      rep;
    logic [2:0]                info_cnt;
    logic [TAIL_INFO-1:0][7:0] info;
    logic                      status_v;
    logic [7:0]                ctrl;
    logic [7:0]                pid;
    logic [8:0]                ilen;
    logic [1:0]                st;
  } run_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  address_slot;
    logic [41:0] callsign_chars;
    logic [2:0]  callsign_length;
    logic [3:0]  ssid;
    logic        repeated;
    logic [7:0]  info_byte;
    logic [7:0]  control_byte;
    logic [7:0]  protocol_id;
    logic [8:0]  info_length;
    logic [1:0]  status;
    logic        last_of_run;
  } res_t;

endpackage

### hdl/ax25p_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for frame bytes in and parse results out
// no dependencies
interface ax25p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface ax25p_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  address_slot;
  logic [41:0] callsign_chars;
  logic [2:0]  callsign_length;
  logic [3:0]  ssid;
  logic        repeated;
  logic [7:0]  info_byte;
  logic [7:0]  control_byte;
  logic [7:0]  protocol_id;
  logic [8:0]  info_length;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (
    output valid, input ready,
    output result_kind, output address_slot, output callsign_chars,
    output callsign_length, output ssid, output repeated, output info_byte,
    output control_byte, output protocol_id, output info_length,
    output status, output last_of_run
  );
  modport sink (
    input valid, output ready,
    input result_kind, input address_slot, input callsign_chars,
    input callsign_length, input ssid, input repeated, input info_byte,
    input control_byte, input protocol_id, input info_length,
    input status, input last_of_run
  );
endinterface

### hdl/ax25p_core.sv
`timescale 1ns / 1ps
// frame state and per-byte decode: computes every result a byte causes
// depends on ax25p_pkg
module ax25p_core #(
  parameter int PATH_MAX = ax25p_pkg::PATH_MAX_DEF,
  parameter int INFO_MAX = ax25p_pkg::INFO_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       frame_byte,
  input  logic             end_of_frame,
  output ax25p_pkg::run_t  run
);

  localparam logic [3:0] RptEnd = 4'(PATH_MAX + 2);
  localparam logic [8:0] InfoLim = 9'(INFO_MAX);

  logic [2:0] phase, phase_next;
  logic [2:0] byte_in_group, byte_in_group_next;
  logic [7:0] group_buffer [ax25p_pkg::GROUP_BUF];
  logic [3:0] address_count, address_count_next;
  logic [4:0] length_seen, length_seen_next;
  logic [8:0] info_count, info_count_next;
  logic [1:0] error_latch, error_latch_next;
  logic [7:0] control_hold, control_hold_next;
  logic [7:0] pid_hold, pid_hold_next;

  logic [7:0] tail [ax25p_pkg::GROUP_BUF];
  logic [2:0] want;
  logic [2:0] taken;
  logic       in_group;

  assign in_group = (phase == ax25p_pkg::PH_DEST) || (phase == ax25p_pkg::PH_SRC) ||
                    (phase == ax25p_pkg::PH_RPT);

  // buffered group with the current byte dropped in at its position
  always_comb begin
    for (int i = 0; i < ax25p_pkg::GROUP_BUF; i++) begin
      tail[i] = (byte_in_group == 3'(i)) ? frame_byte : group_buffer[i];
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_in_group_next = byte_in_group;
    address_count_next = address_count;
    length_seen_next   = (length_seen < 5'(ax25p_pkg::LEN_MIN)) ? length_seen + 5'd1
                                                                : length_seen;
    info_count_next    = info_count;
    error_latch_next   = error_latch;
    control_hold_next  = control_hold;
    pid_hold_next      = pid_hold;
    want               = 3'd0;
    taken              = 3'd0;

    run          = '0;
    run.slot     = address_count;
    run.ssid     = frame_byte[4:1];
    run.clen     = 3'd6;
    for (int i = 0; i < ax25p_pkg::GROUP_BUF; i++) begin
      run.chars[7*i +: 7] = tail[i][7:1];
    end
    for (int i = ax25p_pkg::GROUP_BUF - 1; i >= 0; i--) begin
      if (tail[i][7:1] == ax25p_pkg::CHAR_SPACE) run.clen = 3'(i);
    end

    case (phase)
      ax25p_pkg::PH_DEST, ax25p_pkg::PH_SRC, ax25p_pkg::PH_RPT: begin
        if (byte_in_group != ax25p_pkg::GROUP_LAST) begin
          byte_in_group_next = byte_in_group + 3'd1;
        end else begin
          byte_in_group_next = 3'd0;
          if (phase == ax25p_pkg::PH_DEST) begin
            run.addr_v         = 1'b1;
            run.slot           = ax25p_pkg::SLOT_DEST;
            address_count_next = address_count + 4'd1;
            if (frame_byte[0]) begin
              error_latch_next = ax25p_pkg::ST_PARSE;
              phase_next       = ax25p_pkg::PH_DRAIN;
            end else begin
              phase_next = ax25p_pkg::PH_SRC;
            end
          end else if (phase == ax25p_pkg::PH_SRC) begin
            run.addr_v         = 1'b1;
            run.slot           = ax25p_pkg::SLOT_SRC;
            address_count_next = address_count + 4'd1;
            phase_next = frame_byte[0] ? ax25p_pkg::PH_CTRL : ax25p_pkg::PH_RPT;
          end else if (address_count < ax25p_pkg::SLOT_RPT0 || address_count >= RptEnd) begin
            // path already full
            error_latch_next = ax25p_pkg::ST_OVERFLOW;
            phase_next       = ax25p_pkg::PH_DRAIN;
          end else begin
            run.addr_v         = 1'b1;
            run.rep            = frame_byte[7];
            address_count_next = address_count + 4'd1;
            if (frame_byte[0]) phase_next = ax25p_pkg::PH_CTRL;
          end
        end
      end
      ax25p_pkg::PH_CTRL: begin
        control_hold_next = frame_byte;
        phase_next        = ax25p_pkg::PH_PID;
      end
      ax25p_pkg::PH_PID: begin
        pid_hold_next = frame_byte;
        if (control_hold != ax25p_pkg::CTRL_UI) begin
          error_latch_next = ax25p_pkg::ST_NOT_UI;
          phase_next       = ax25p_pkg::PH_DRAIN;
        end else begin
          phase_next = ax25p_pkg::PH_INFO;
        end
      end
      ax25p_pkg::PH_INFO: begin
        if (info_count >= InfoLim) begin
          error_latch_next = ax25p_pkg::ST_OVERFLOW;
          phase_next       = ax25p_pkg::PH_DRAIN;
        end else begin
          run.info_cnt    = 3'd1;
          run.info[0]     = frame_byte;
          info_count_next = info_count + 9'd1;
        end
      end
      default: begin
      end
    endcase

    if (end_of_frame) begin
      // a partial repeater group turns out to be control, pid and info
      if (phase_next == ax25p_pkg::PH_RPT && byte_in_group_next >= 3'd2) begin
        want              = byte_in_group_next - 3'd2;
        control_hold_next = tail[0];
        pid_hold_next     = tail[1];
        if (tail[0] != ax25p_pkg::CTRL_UI) begin
          error_latch_next = ax25p_pkg::ST_NOT_UI;
          phase_next       = ax25p_pkg::PH_DRAIN;
        end else if (9'(want) > InfoLim) begin
          taken            = 3'(INFO_MAX);
          error_latch_next = ax25p_pkg::ST_OVERFLOW;
          phase_next       = ax25p_pkg::PH_DRAIN;
        end else begin
          taken      = want;
          phase_next = ax25p_pkg::PH_INFO;
        end
        for (int j = 0; j < ax25p_pkg::TAIL_INFO; j++) begin
          run.info[j] = tail[j+2];
        end
        run.info_cnt    = taken;
        info_count_next = 9'(taken);
      end

      run.status_v = 1'b1;
      run.ctrl     = control_hold_next;
      run.pid      = pid_hold_next;
      run.ilen     = info_count_next;
      if (length_seen_next < 5'(ax25p_pkg::LEN_MIN)) run.st = ax25p_pkg::ST_PARSE;
      else if (error_latch_next != ax25p_pkg::ST_OK) run.st = error_latch_next;
      else if (phase_next == ax25p_pkg::PH_INFO) run.st = ax25p_pkg::ST_OK;
      else run.st = ax25p_pkg::ST_PARSE;

      phase_next         = ax25p_pkg::PH_DEST;
      byte_in_group_next = 3'd0;
      address_count_next = 4'd0;
      length_seen_next   = 5'd0;
      info_count_next    = 9'd0;
      error_latch_next   = ax25p_pkg::ST_OK;
      control_hold_next  = 8'd0;
      pid_hold_next      = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ax25p_pkg::PH_DEST;
      byte_in_group <= 3'd0;
      address_count <= 4'd0;
      length_seen   <= 5'd0;
      info_count    <= 9'd0;
      error_latch   <= ax25p_pkg::ST_OK;
      control_hold  <= 8'd0;
      pid_hold      <= 8'd0;
    end else if (take) begin
      phase         <= phase_next;
      byte_in_group <= byte_in_group_next;
      address_count <= address_count_next;
      length_seen   <= length_seen_next;
      info_count    <= info_count_next;
      error_latch   <= error_latch_next;
      control_hold  <= control_hold_next;
      pid_hold      <= pid_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_group && byte_in_group != ax25p_pkg::GROUP_LAST) begin
      group_buffer[byte_in_group] <= frame_byte;
    end
  end

endmodule

### hdl/ax25_ui_frame_parser_top.sv
`timescale 1ns / 1ps
// each accepted byte's results are registered in a result buffer, then moved one by one into the output register
// throughput: one byte per cycle while the output is ready; a byte that causes k results (k up to 5)
//   holds the input until the result buffer has drained, one a cycle while the output is ready
// reset: synchronous rst returns the parser to awaiting a destination address
//   and empties the result buffer and output register
module ax25_ui_frame_parser_top #(
  parameter int PATH_MAX = ax25p_pkg::PATH_MAX_DEF,
  parameter int INFO_MAX = ax25p_pkg::INFO_MAX_DEF
) (
  input logic         clk,
  input logic         rst,
  ax25p_in_if.sink    frame_in,
  ax25p_out_if.source result_out
);

  ax25p_pkg::run_t run_new;
  ax25p_pkg::run_t run;
  ax25p_pkg::res_t res;
  ax25p_pkg::res_t pick;

  logic [2:0] run_n, run_idx, new_n, info_idx;
  logic       pending, move, last_move, take, out_valid;

  ax25p_core #(
    .PATH_MAX (PATH_MAX),
    .INFO_MAX (INFO_MAX)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .frame_byte   (frame_in.frame_byte),
    .end_of_frame (frame_in.end_of_frame),
    .run          (run_new)
  );

  assign new_n = 3'(run_new.addr_v) + run_new.info_cnt + 3'(run_new.status_v);

  assign pending   = (run_idx != run_n);
  assign move      = pending && (!out_valid || result_out.ready);
  assign last_move = move && (run_idx == run_n - 3'd1);
  assign frame_in.ready = !pending || last_move;
  assign take      = frame_in.valid && frame_in.ready;

  // pick the buffered result at run_idx
  always_comb begin
    info_idx = run_idx - 3'(run.addr_v);
    pick     = '0;
    pick.last_of_run = (run_idx == run_n - 3'd1);
    if (run.addr_v && run_idx == 3'd0) begin
      pick.result_kind     = ax25p_pkg::KIND_ADDR;
      pick.address_slot    = run.slot;
      pick.callsign_chars  = run.chars;
      pick.callsign_length = run.clen;
      pick.ssid            = run.ssid;
      pick.repeated        = run.rep;
    end else if (info_idx < run.info_cnt) begin
      pick.result_kind = ax25p_pkg::KIND_INFO;
      pick.info_byte   = run.info[info_idx[1:0]];
    end else begin
      pick.result_kind  = ax25p_pkg::KIND_STATUS;
      pick.control_byte = run.ctrl;
      pick.protocol_id  = run.pid;
      pick.info_length  = run.ilen;
      pick.status       = run.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_n     <= 3'd0;
      run_idx   <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        run_n   <= new_n;
        run_idx <= 3'd0;
      end else if (move) begin
        run_idx <= run_idx + 3'd1;
      end
      if (move) out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) run <= run_new;
    if (move) res <= pick;
  end

  assign result_out.valid           = out_valid;
  assign result_out.result_kind     = res.result_kind;
  assign result_out.address_slot    = res.address_slot;
  assign result_out.callsign_chars  = res.callsign_chars;
  assign result_out.callsign_length = res.callsign_length;
  assign result_out.ssid            = res.ssid;
  assign result_out.repeated        = res.repeated;
  assign result_out.info_byte       = res.info_byte;
  assign result_out.control_byte    = res.control_byte;
  assign result_out.protocol_id     = res.protocol_id;
  assign result_out.info_length     = res.info_length;
  assign result_out.status          = res.status;
  assign result_out.last_of_run     = res.last_of_run;

endmodule

### hdl/ax25p_checker.sv
`timescale 1ns / 1ps
// port-level checks on the parser outputs, bound to the top level
// depends on ax25p_pkg and ax25_ui_frame_parser_top
module ax25p_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] result_kind,
  input logic [3:0] address_slot,
  input logic       repeated,
  input logic       last_of_run
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // the status result always closes the run of its byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == ax25p_pkg::KIND_STATUS |-> last_of_run)
    else $error("status result not last of its run");

  a_no_h_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == ax25p_pkg::KIND_ADDR &&
    address_slot < ax25p_pkg::SLOT_RPT0 |-> !repeated)
    else $error("h bit set on destination or source address");

endmodule

bind ax25_ui_frame_parser_top ax25p_checker u_ax25p_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .result_kind  (result_out.result_kind),
  .address_slot (result_out.address_slot),
  .repeated     (result_out.repeated),
  .last_of_run  (result_out.last_of_run)
);
